// ===== hw/rtl/htfd_pkg.sv =====
`timescale 1ns / 1ps

package htfd_pkg;

    // field widths
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned RAW_W    = 20;
    localparam int unsigned TENTHS_W = 16;
    localparam int unsigned WHOLE_W  = 13;
    localparam int unsigned DATA_W   = 40;
    localparam int unsigned CFG_W    = 16;
    localparam int unsigned HSCL_W   = 10;
    localparam int unsigned TSCL_W   = 11;
    localparam int unsigned TDATA_W  = 112;

    // crc-8 settings
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [7:0] CRC_POLY = 8'h31;

    // scaling constants, codes are full scale at 2^20
    localparam logic [29:0] HUM_SCALE  = 30'd1000;
    localparam logic [30:0] TEMP_SCALE = 31'd2000;
    localparam logic [15:0] TEMP_BIAS  = 16'd500;

    // fallback values and failure handling
    localparam logic [15:0] FALLBACK_TEMP   = 16'd285;
    localparam logic [15:0] FALLBACK_HUM    = 16'd567;
    localparam logic [7:0]  FAIL_MAX        = 8'd255;
    localparam logic [7:0]  ERR_LIMIT_RESET = 8'd5;
    localparam int unsigned FRAME_LAST_POS  = 6;

    // divide by ten: multiply by 2^19/10 rounded up, exact below 2^18
    localparam logic [33:0] RECIP_TEN   = 34'd52429;
    localparam int unsigned RECIP_SHIFT = 19;
    localparam logic [16:0] ROUND_HALF  = 17'd5;

    // configuration register indexes
    typedef enum logic [1:0] {
        CFG_ERROR_LIMIT = 2'd0,
        CFG_TEMP_OFFSET = 2'd1,
        CFG_HUM_OFFSET  = 2'd2
    } t_cfg_idx;

    // role of a byte inside the reply
    typedef enum logic [1:0] {
        BK_START = 2'd0,
        BK_DATA  = 2'd1,
        BK_CHECK = 2'd2
    } t_beat_kind;

    typedef struct packed {
        t_beat_kind         kind;
        logic [BYTE_W-1:0]  data;
    } t_beat;

    typedef struct packed {
        logic [BYTE_W-1:0]          error_limit;
        logic signed [CFG_W-1:0]    temp_offset;
        logic signed [CFG_W-1:0]    hum_offset;
    } t_cfg;

    typedef struct packed {
        logic               crc_ok;
        logic [BYTE_W-1:0]  status;
        logic [RAW_W-1:0]   hum_raw;
        logic [RAW_W-1:0]   temp_raw;
        logic [HSCL_W-1:0]  hum_scaled;
        logic [TSCL_W-1:0]  temp_scaled;
    } t_frame;

    typedef struct packed {
        logic                       crc_ok;
        logic [BYTE_W-1:0]          status;
        logic [RAW_W-1:0]           hum_raw;
        logic [RAW_W-1:0]           temp_raw;
        logic signed [TENTHS_W-1:0] hum_tenths;
        logic signed [TENTHS_W-1:0] temp_tenths;
        logic signed [WHOLE_W-1:0]  hum_whole;
        logic signed [WHOLE_W-1:0]  temp_whole;
        logic                       sensor_valid;
        logic                       reinit;
    } t_result;

    // one byte through crc-8, msb first
    function automatic logic [7:0] f_crc_byte(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

    // tenths to whole units: round half up when positive, truncate when negative
    function automatic logic signed [WHOLE_W-1:0] f_whole(input logic signed [TENTHS_W-1:0] t);
        logic [16:0] mag;
        logic [33:0] prod;
        logic [WHOLE_W-1:0] q;
        if (t[TENTHS_W-1]) begin
            mag = 17'd0 - {t[TENTHS_W-1], t};
        end else begin
            mag = {1'b0, t} + ROUND_HALF;
        end
        prod = 34'(mag) * RECIP_TEN;
        q = prod[RECIP_SHIFT +: WHOLE_W];
        if (t[TENTHS_W-1]) begin
            return -$signed(q);
        end
        return $signed(q);
    endfunction

endpackage

// ===== hw/rtl/humidity_temp_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// channel   dir  signals                        contents
// s_axis    in   i_s_tvalid/o_s_tready          tdata: rx_byte; tuser: frame_start
// m_axis    out  o_m_tvalid/i_m_tready          tdata: one decoded reply
// cfg       in   i_cfg_wr_en/index/data         error_limit, temperature_offset, humidity_offset
//
// one reply byte per cycle while o_s_tready is high
// stages: input register, crc and unpack, failure tracking, rounding, two-entry output queue
// o_s_tready drops only while two results are queued or in flight
// synchronous active-low reset; config reset values: limit 5, offsets 0

module humidity_temp_frame_decoder_unit (
    input  logic            i_clk,
    input  logic            i_rst_n,
    // rx_byte[7:0]
    input  logic [7:0]      i_s_tdata,
    // frame_start[0]
    input  logic            i_s_tuser,
    input  logic            i_s_tvalid,
    output logic            o_s_tready,
    // crc_ok[0], status_byte[8:1], humidity_raw[28:9], temperature_raw[48:29],
    // humidity_tenths[64:49], temperature_tenths[80:65], humidity_whole[93:81],
    // temperature_whole[106:94], sensor_valid[107], reinit_request[108], zero[111:109]
    output logic [htfd_pkg::TDATA_W-1:0] o_m_tdata,
    output logic            o_m_tvalid,
    input  logic            i_m_tready,
    input  logic            i_cfg_wr_en,
    input  logic [1:0]      i_cfg_index,
    input  logic [15:0]     i_cfg_data
);

    logic                       w_in_acc;
    logic                       w_q_push;
    logic                       w_q_pop;
    logic [2:0]                 w_pend;
    logic                       w_s0_chk;

    logic [2:0]                 r_pos;
    logic [2:0]                 n_pos;
    logic                       r_s0_vld;
    logic                       n_s0_vld;
    htfd_pkg::t_beat            r_s0;
    htfd_pkg::t_beat            n_s0;

    htfd_pkg::t_cfg             r_cfg;

    logic                       w_s1_vld;
    htfd_pkg::t_frame           w_s1;
    logic                       w_s2_busy;
    logic                       w_s3_vld;
    htfd_pkg::t_result          w_s3;

    htfd_pkg::t_result          r_q_mem [2];
    logic                       r_q_wptr;
    logic                       r_q_rptr;
    logic [1:0]                 r_q_cnt;
    htfd_pkg::t_result          w_head;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.error_limit <= htfd_pkg::ERR_LIMIT_RESET;
            r_cfg.temp_offset <= '0;
            r_cfg.hum_offset  <= '0;
        end else if (i_cfg_wr_en) begin
            case (htfd_pkg::t_cfg_idx'(i_cfg_index))
                htfd_pkg::CFG_ERROR_LIMIT: r_cfg.error_limit <= i_cfg_data[7:0];
                htfd_pkg::CFG_TEMP_OFFSET: r_cfg.temp_offset <= i_cfg_data;
                htfd_pkg::CFG_HUM_OFFSET:  r_cfg.hum_offset  <= i_cfg_data;
                default: r_cfg <= r_cfg;
            endcase
        end
    end

    // results queued or still on their way to the queue
    assign w_s0_chk   = r_s0_vld && (r_s0.kind == htfd_pkg::BK_CHECK);
    assign w_pend     = 3'(r_q_cnt) + 3'(w_s0_chk) + 3'(w_s1_vld) + 3'(w_s2_busy)
                      + 3'(w_s3_vld);
    assign o_s_tready = (w_pend < 3'd2);
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // byte position inside the reply, classifies each accepted beat
    always_comb begin
        n_pos        = r_pos;
        n_s0_vld     = 1'b0;
        n_s0.data    = i_s_tdata;
        n_s0.kind    = htfd_pkg::BK_DATA;
        if (w_in_acc) begin
            if (i_s_tuser) begin
                n_pos     = 3'd1;
                n_s0_vld  = 1'b1;
                n_s0.kind = htfd_pkg::BK_START;
            end else if (r_pos == 3'd0) begin
                n_s0_vld  = 1'b0;
            end else if (r_pos < 3'(htfd_pkg::FRAME_LAST_POS)) begin
                n_pos     = r_pos + 3'd1;
                n_s0_vld  = 1'b1;
            end else begin
                n_pos     = 3'd0;
                n_s0_vld  = 1'b1;
                n_s0.kind = htfd_pkg::BK_CHECK;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_s0_vld <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_s0_vld <= n_s0_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
    end

    htfd_frame u_frame (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_s0_vld),
        .i_beat  (r_s0),
        .o_vld   (w_s1_vld),
        .o_frame (w_s1)
    );

    htfd_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_s1_vld),
        .i_frame (w_s1),
        .i_cfg   (r_cfg),
        .o_busy  (w_s2_busy),
        .o_vld   (w_s3_vld),
        .o_res   (w_s3)
    );

    // two-entry output queue
    assign w_q_push = w_s3_vld;
    assign w_q_pop  = o_m_tvalid && i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wptr <= 1'b0;
            r_q_rptr <= 1'b0;
            r_q_cnt  <= '0;
        end else begin
            if (w_q_push) begin
                r_q_wptr <= ~r_q_wptr;
            end
            if (w_q_pop) begin
                r_q_rptr <= ~r_q_rptr;
            end
            r_q_cnt <= r_q_cnt + 2'(w_q_push) - 2'(w_q_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_q_push) begin
            r_q_mem[r_q_wptr] <= w_s3;
        end
    end

    assign w_head     = r_q_mem[r_q_rptr];
    assign o_m_tvalid = (r_q_cnt != 2'd0);
    assign o_m_tdata  = {3'b000, w_head.reinit, w_head.sensor_valid,
                         w_head.temp_whole, w_head.hum_whole,
                         w_head.temp_tenths, w_head.hum_tenths,
                         w_head.temp_raw, w_head.hum_raw,
                         w_head.status, w_head.crc_ok};

    // the queue never receives a beat while full, unless one leaves in the same cycle
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_push && !w_q_pop) |-> (r_q_cnt < 2'd2))
        else $error("output queue overflow");

    // at most one result is ever inside the pipeline
    a_one_inflight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones({w_s0_chk, w_s1_vld, w_s2_busy, w_s3_vld}) <= 1)
        else $error("more than one result in flight");

    // fallback always comes with the valid flag low and fallback values
    a_fallback: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_push && w_s3.reinit) |->
        (!w_s3.sensor_valid && w_s3.temp_tenths == htfd_pkg::FALLBACK_TEMP
         && w_s3.hum_tenths == htfd_pkg::FALLBACK_HUM))
        else $error("fallback values inconsistent");

    // a crc mismatch never carries sensor codes
    a_crc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_push && !w_s3.crc_ok) |-> (w_s3.hum_raw == '0 && w_s3.temp_raw == '0))
        else $error("codes leaked on crc mismatch");

endmodule

// ===== hw/rtl/htfd_frame.sv =====
`timescale 1ns / 1ps

module htfd_frame (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  htfd_pkg::t_beat         i_beat,
    output logic                    o_vld,
    output htfd_pkg::t_frame        o_frame
);

    logic [7:0]                     r_crc;
    logic [7:0]                     n_crc;
    logic [htfd_pkg::DATA_W-1:0]    r_data;
    logic [htfd_pkg::DATA_W-1:0]    n_data;
    logic [htfd_pkg::BYTE_W-1:0]    r_status;
    logic [htfd_pkg::BYTE_W-1:0]    n_status;
    logic                           r_out_vld;
    logic                           n_out_vld;
    htfd_pkg::t_frame               r_frame;
    htfd_pkg::t_frame               n_frame;

    logic                           w_ok;
    logic [htfd_pkg::RAW_W-1:0]     w_hraw;
    logic [htfd_pkg::RAW_W-1:0]     w_traw;
    logic [29:0]                    w_hprod;
    logic [30:0]                    w_tprod;

    // check byte: compare and unpack, codes forced to zero on mismatch
    assign w_ok    = (r_crc == i_beat.data);
    assign w_hraw  = w_ok ? r_data[htfd_pkg::DATA_W-1 -: htfd_pkg::RAW_W] : '0;
    assign w_traw  = w_ok ? r_data[htfd_pkg::RAW_W-1:0] : '0;
    assign w_hprod = 30'(w_hraw) * htfd_pkg::HUM_SCALE;
    assign w_tprod = 31'(w_traw) * htfd_pkg::TEMP_SCALE;

    // frame assembly per beat
    always_comb begin
        n_crc     = r_crc;
        n_data    = r_data;
        n_status  = r_status;
        n_out_vld = 1'b0;
        n_frame   = r_frame;
        if (i_vld) begin
            case (i_beat.kind)
                htfd_pkg::BK_START: begin
                    n_status = i_beat.data;
                    n_crc    = htfd_pkg::f_crc_byte(htfd_pkg::CRC_INIT, i_beat.data);
                    n_data   = '0;
                end
                htfd_pkg::BK_DATA: begin
                    n_crc  = htfd_pkg::f_crc_byte(r_crc, i_beat.data);
                    n_data = {r_data[htfd_pkg::DATA_W-htfd_pkg::BYTE_W-1:0], i_beat.data};
                end
                htfd_pkg::BK_CHECK: begin
                    n_crc               = htfd_pkg::CRC_INIT;
                    n_out_vld           = 1'b1;
                    n_frame.crc_ok      = w_ok;
                    n_frame.status      = r_status;
                    n_frame.hum_raw     = w_hraw;
                    n_frame.temp_raw    = w_traw;
                    n_frame.hum_scaled  = w_hprod[29 -: htfd_pkg::HSCL_W];
                    n_frame.temp_scaled = w_tprod[30 -: htfd_pkg::TSCL_W];
                end
                default: begin
                    n_out_vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc     <= htfd_pkg::CRC_INIT;
            r_data    <= '0;
            r_status  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_crc     <= n_crc;
            r_data    <= n_data;
            r_status  <= n_status;
            r_out_vld <= n_out_vld;
        end
    end

    // payload register
    always_ff @(posedge i_clk) begin
        r_frame <= n_frame;
    end

    assign o_vld   = r_out_vld;
    assign o_frame = r_frame;

endmodule

// ===== hw/rtl/htfd_track.sv =====
`timescale 1ns / 1ps

module htfd_track (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_vld,
    input  htfd_pkg::t_frame        i_frame,
    input  htfd_pkg::t_cfg          i_cfg,
    output logic                    o_busy,
    output logic                    o_vld,
    output htfd_pkg::t_result       o_res
);

    logic [7:0]                         r_fail_cnt;
    logic [7:0]                         n_fail_cnt;
    logic [htfd_pkg::TENTHS_W-1:0]      r_held_hum;
    logic [htfd_pkg::TENTHS_W-1:0]      n_held_hum;
    logic [htfd_pkg::TENTHS_W-1:0]      r_held_temp;
    logic [htfd_pkg::TENTHS_W-1:0]      n_held_temp;
    logic                               r_valid;
    logic                               n_valid;
    logic                               n_reinit;
    logic                               w_fail;

    logic                               r_s2_vld;
    htfd_pkg::t_result                  r_s2;
    logic                               r_s3_vld;
    htfd_pkg::t_result                  r_s3;
    htfd_pkg::t_result                  n_s3;

    assign w_fail = !i_frame.crc_ok || (i_frame.hum_raw == '0 && i_frame.temp_raw == '0);

    // failure count, held values and fallback
    always_comb begin
        n_fail_cnt  = r_fail_cnt;
        n_held_hum  = r_held_hum;
        n_held_temp = r_held_temp;
        n_valid     = r_valid;
        n_reinit    = 1'b0;
        if (w_fail) begin
            if (r_fail_cnt != htfd_pkg::FAIL_MAX) begin
                n_fail_cnt = r_fail_cnt + 8'd1;
            end
        end else begin
            n_fail_cnt  = '0;
            n_held_hum  = 16'(i_frame.hum_scaled) + i_cfg.hum_offset;
            n_held_temp = 16'(i_frame.temp_scaled) - htfd_pkg::TEMP_BIAS + i_cfg.temp_offset;
            n_valid     = 1'b1;
        end
        if (n_fail_cnt > i_cfg.error_limit) begin
            n_held_hum  = htfd_pkg::FALLBACK_HUM;
            n_held_temp = htfd_pkg::FALLBACK_TEMP;
            n_valid     = 1'b0;
            n_reinit    = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fail_cnt  <= '0;
            r_held_hum  <= '0;
            r_held_temp <= '0;
            r_valid     <= 1'b0;
            r_s2_vld    <= 1'b0;
            r_s3_vld    <= 1'b0;
        end else begin
            if (i_vld) begin
                r_fail_cnt  <= n_fail_cnt;
                r_held_hum  <= n_held_hum;
                r_held_temp <= n_held_temp;
                r_valid     <= n_valid;
            end
            r_s2_vld <= i_vld;
            r_s3_vld <= r_s2_vld;
        end
    end

    // published values, whole units are filled in the next stage
    always_ff @(posedge i_clk) begin
        r_s2.crc_ok       <= i_frame.crc_ok;
        r_s2.status       <= i_frame.status;
        r_s2.hum_raw      <= i_frame.hum_raw;
        r_s2.temp_raw     <= i_frame.temp_raw;
        r_s2.hum_tenths   <= n_held_hum;
        r_s2.temp_tenths  <= n_held_temp;
        r_s2.hum_whole    <= '0;
        r_s2.temp_whole   <= '0;
        r_s2.sensor_valid <= n_valid;
        r_s2.reinit       <= n_reinit;
    end

    // rounding to whole units
    always_comb begin
        n_s3            = r_s2;
        n_s3.hum_whole  = htfd_pkg::f_whole(r_s2.hum_tenths);
        n_s3.temp_whole = htfd_pkg::f_whole(r_s2.temp_tenths);
    end

    always_ff @(posedge i_clk) begin
        r_s3 <= n_s3;
    end

    assign o_busy = r_s2_vld;
    assign o_vld  = r_s3_vld;
    assign o_res  = r_s3;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

    localparam int          CYCLE_LIMIT     = 400000;
    localparam int          SETTLE_CYCLES   = 16;
    localparam int          MAX_REPORTS     = 10;
    localparam logic [7:0]  CRC_SEED        = 8'hFF;
    localparam logic [7:0]  CRC_POLY_BITS   = 8'h31;
    localparam logic [2:0]  LAST_DATA_POS   = 3'd6;
    localparam logic [7:0]  FAIL_SATURATE   = 8'hFF;
    localparam logic [7:0]  LIMIT_DEFAULT   = 8'd5;
    localparam logic [29:0] HUM_FULL_SCALE  = 30'd1000;
    localparam logic [30:0] TEMP_FULL_SCALE = 31'd2000;
    localparam logic [15:0] TEMP_BIAS       = 16'd500;
    localparam logic [15:0] FALLBACK_TEMP_T = 16'd285;
    localparam logic [15:0] FALLBACK_HUM_T  = 16'd567;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PERIODIC,
        RX_LONG
    } t_rx_stall_mode;

    // one decoded reply as it should leave the block
    typedef struct {
        logic        crc_ok;
        logic [7:0]  status;
        logic [19:0] hum_raw;
        logic [19:0] temp_raw;
        logic [15:0] hum_tenths;
        logic [15:0] temp_tenths;
        logic [12:0] hum_whole;
        logic [12:0] temp_whole;
        logic        sensor_valid;
        logic        reinit;
    } t_reading;

    // reply decoder prediction and comparison against the output stream
    class decoder_scoreboard;
        logic [7:0]  error_limit;
        logic [15:0] temp_offset;
        logic [15:0] hum_offset;
        logic [2:0]  byte_pos;
        logic [7:0]  running_crc;
        logic [39:0] data_bytes;
        logic [7:0]  saved_status;
        logic [7:0]  fail_count;
        logic [15:0] held_temp;
        logic [15:0] held_hum;
        logic        valid_flag;
        t_reading    expected_readings[$];
        int          mismatches;

        function new();
            error_limit  = LIMIT_DEFAULT;
            temp_offset  = '0;
            hum_offset   = '0;
            byte_pos     = '0;
            running_crc  = CRC_SEED;
            data_bytes   = '0;
            saved_status = '0;
            fail_count   = '0;
            held_temp    = '0;
            held_hum     = '0;
            valid_flag   = 1'b0;
            mismatches   = 0;
        endfunction

        static function logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            c = crc ^ b;
            for (int i = 0; i < 8; i++) begin
                if (c[7]) begin
                    c = {c[6:0], 1'b0} ^ CRC_POLY_BITS;
                end else begin
                    c = {c[6:0], 1'b0};
                end
            end
            return c;
        endfunction

        // round half up for positive tenths, truncate toward zero otherwise
        static function logic [12:0] to_whole(logic [15:0] tenths);
            int t;
            int q;
            t = int'($signed(tenths));
            q = t / 10;
            if (t % 10 >= 5) begin
                q = q + 1;
            end
            return 13'(q);
        endfunction

        function void set_config(htfd_pkg::t_cfg_idx idx, logic [15:0] value);
            case (idx)
                htfd_pkg::CFG_ERROR_LIMIT: error_limit = value[7:0];
                htfd_pkg::CFG_TEMP_OFFSET: temp_offset = value;
                htfd_pkg::CFG_HUM_OFFSET:  hum_offset  = value;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_readings.size();
        endfunction

        // advance the reply state by one accepted beat
        function void note_beat(logic [7:0] b, logic start);
            t_reading    r;
            logic        ok;
            logic        failed;
            logic [19:0] hraw;
            logic [19:0] traw;
            logic [29:0] hprod;
            logic [30:0] tprod;
            if (start) begin
                saved_status = b;
                running_crc  = crc8_step(CRC_SEED, b);
                data_bytes   = '0;
                byte_pos     = 3'd1;
                return;
            end
            if (byte_pos == 3'd0) begin
                return;
            end
            if (byte_pos < LAST_DATA_POS) begin
                running_crc = crc8_step(running_crc, b);
                data_bytes  = {data_bytes[31:0], b};
                byte_pos    = byte_pos + 3'd1;
                return;
            end

            // check byte closes the reply
            byte_pos    = 3'd0;
            ok          = (running_crc == b);
            running_crc = CRC_SEED;
            hraw        = ok ? data_bytes[39:20] : 20'd0;
            traw        = ok ? data_bytes[19:0] : 20'd0;
            failed      = !ok || (hraw == 20'd0 && traw == 20'd0);
            if (failed) begin
                if (fail_count != FAIL_SATURATE) begin
                    fail_count = fail_count + 8'd1;
                end
            end else begin
                hprod      = 30'(hraw) * HUM_FULL_SCALE;
                tprod      = 31'(traw) * TEMP_FULL_SCALE;
                fail_count = '0;
                held_hum   = 16'(hprod[29:20]) + hum_offset;
                held_temp  = 16'(tprod[30:20]) - TEMP_BIAS + temp_offset;
                valid_flag = 1'b1;
            end
            r.reinit = 1'b0;
            if (fail_count > error_limit) begin
                held_temp  = FALLBACK_TEMP_T;
                held_hum   = FALLBACK_HUM_T;
                valid_flag = 1'b0;
                r.reinit   = 1'b1;
            end
            r.crc_ok       = ok;
            r.status       = saved_status;
            r.hum_raw      = hraw;
            r.temp_raw     = traw;
            r.hum_tenths   = held_hum;
            r.temp_tenths  = held_temp;
            r.hum_whole    = to_whole(held_hum);
            r.temp_whole   = to_whole(held_temp);
            r.sensor_valid = valid_flag;
            expected_readings.push_back(r);
        endfunction

        function void compare_field(string field, logic [19:0] want, logic [19:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] mismatch in %s: expected %h, got %h",
                             $realtime, field, want, got);
                end
            end
        endfunction

        function void check_reading(logic [111:0] tdata);
            t_reading e;
            if (expected_readings.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] unexpected reading %h", $realtime, tdata);
                end
                return;
            end
            e = expected_readings.pop_front();
            compare_field("crc_ok",             20'(e.crc_ok),       20'(tdata[0]));
            compare_field("status_byte",        20'(e.status),       20'(tdata[8:1]));
            compare_field("humidity_raw",       e.hum_raw,           tdata[28:9]);
            compare_field("temperature_raw",    e.temp_raw,          tdata[48:29]);
            compare_field("humidity_tenths",    20'(e.hum_tenths),   20'(tdata[64:49]));
            compare_field("temperature_tenths", 20'(e.temp_tenths),  20'(tdata[80:65]));
            compare_field("humidity_whole",     20'(e.hum_whole),    20'(tdata[93:81]));
            compare_field("temperature_whole",  20'(e.temp_whole),   20'(tdata[106:94]));
            compare_field("sensor_valid",       20'(e.sensor_valid), 20'(tdata[107]));
            compare_field("reinit_request",     20'(e.reinit),       20'(tdata[108]));
            compare_field("padding",            20'd0,               20'(tdata[111:109]));
        endfunction
    endclass

    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic [7:0]     i_s_tdata   = '0;
    logic           i_s_tuser   = 1'b0;
    logic           i_s_tvalid  = 1'b0;
    logic           o_s_tready;
    logic [111:0]   o_m_tdata;
    logic           o_m_tvalid;
    logic           i_m_tready  = 1'b0;
    logic           i_cfg_wr_en = 1'b0;
    logic [1:0]     i_cfg_index = htfd_pkg::CFG_ERROR_LIMIT;
    logic [15:0]    i_cfg_data  = '0;

    decoder_scoreboard sb = new();

    int             burst_left  = 0;
    int             beats_sent  = 0;
    int             rx_count    = 0;
    t_rx_stall_mode rx_mode     = RX_ALWAYS;

    humidity_temp_frame_decoder_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // receiver stalls, pattern picked at random
    always @(posedge i_clk) begin
        rx_count = rx_count + 1;
        if (rx_count % 64 == 0) begin
            rx_mode = t_rx_stall_mode'($urandom_range(0, 3));
        end
        case (rx_mode)
            RX_ALWAYS:   i_m_tready <= 1'b1;
            RX_RANDOM:   i_m_tready <= ($urandom_range(0, 3) != 0);
            RX_PERIODIC: i_m_tready <= (rx_count % 5 > 1);
            default:     i_m_tready <= (rx_count % 16 < 8);
        endcase
    end

    // output beat monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_reading(o_m_tdata);
        end
    end

    // watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    // one input beat, sent in bursts with random gaps
    task automatic send_beat(input logic [7:0] b, input logic start);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= b;
        i_s_tuser  <= start;
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        sb.note_beat(b, start);
    endtask

    // a reply cut to n_bytes, check byte xor'ed with crc_flip
    task automatic send_reply(input logic [7:0] status, input logic [19:0] hraw,
                              input logic [19:0] traw, input logic [7:0] crc_flip,
                              input int n_bytes);
        logic [7:0]  reply [0:6];
        logic [39:0] d;
        logic [7:0]  c;
        d        = {hraw, traw};
        reply[0] = status;
        for (int i = 1; i < 6; i++) begin
            reply[i] = d[47 - 8 * i -: 8];
        end
        c = CRC_SEED;
        for (int i = 0; i < 6; i++) begin
            c = decoder_scoreboard::crc8_step(c, reply[i]);
        end
        reply[6] = c ^ crc_flip;
        for (int i = 0; i < n_bytes; i++) begin
            send_beat(reply[i], i == 0);
        end
        beats_sent += n_bytes;
    endtask

    function automatic logic [19:0] pick_code();
        case ($urandom_range(0, 5))
            0:       return 20'd0;
            1:       return 20'hFFFFF;
            2:       return 20'($urandom_range(1, 255));
            default: return 20'($urandom);
        endcase
    endfunction

    task automatic failure_run(input int n);
        repeat (n) begin
            send_reply(8'($urandom), pick_code(), pick_code(),
                       8'h01 << $urandom_range(0, 7), 7);
        end
    endtask

    // mostly well-formed replies, plus corrupt, empty, cut-off and stray bytes
    task automatic random_traffic(input int n_beats);
        int first;
        int kind;
        first = beats_sent;
        while (beats_sent - first < n_beats) begin
            kind = $urandom_range(0, 99);
            if (kind < 55) begin
                send_reply(8'($urandom), pick_code(), pick_code(), 8'h00, 7);
            end else if (kind < 67) begin
                send_reply(8'($urandom), pick_code(), pick_code(),
                           8'($urandom_range(1, 255)), 7);
            end else if (kind < 74) begin
                send_reply(8'($urandom), 20'd0, 20'd0, 8'h00, 7);
            end else if (kind < 82) begin
                send_reply(8'($urandom), pick_code(), pick_code(), 8'h00,
                           $urandom_range(1, 6));
            end else if (kind < 90) begin
                failure_run($urandom_range(2, 6));
            end else begin
                repeat ($urandom_range(1, 3)) send_beat(8'($urandom), 1'b0);
            end
        end
    endtask

    task automatic cfg_write(input htfd_pkg::t_cfg_idx idx, input logic [15:0] value);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.set_config(idx, value);
        @(posedge i_clk);
    endtask

    // drain all readings, then let cut-off replies settle
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: stray byte, full-scale codes, restart inside a reply,
        // zero codes with good crc, bad crc
        send_beat(8'hA5, 1'b0);
        send_reply(8'hFF, 20'hFFFFF, 20'hFFFFF, 8'h00, 7);
        send_reply(8'h1C, 20'h80000, 20'h66666, 8'h00, 3);
        send_reply(8'h00, 20'd0, 20'd0, 8'h00, 7);
        send_reply(8'h18, 20'h12345, 20'h01000, 8'h80, 7);
        wait_idle();

        // fallback on first failure, offsets at the wrapping extremes
        cfg_write(htfd_pkg::CFG_ERROR_LIMIT, 16'd0);
        cfg_write(htfd_pkg::CFG_TEMP_OFFSET, 16'h7FFF);
        cfg_write(htfd_pkg::CFG_HUM_OFFSET, 16'h8000);
        random_traffic(90);
        wait_idle();

        // limit at saturation never falls back
        cfg_write(htfd_pkg::CFG_ERROR_LIMIT, 16'd255);
        cfg_write(htfd_pkg::CFG_TEMP_OFFSET, 16'h8000);
        cfg_write(htfd_pkg::CFG_HUM_OFFSET, 16'h7FFF);
        failure_run(12);
        random_traffic(50);
        wait_idle();

        // highest limit that can still fall back, under a run of failures
        cfg_write(htfd_pkg::CFG_ERROR_LIMIT, 16'd254);
        cfg_write(htfd_pkg::CFG_TEMP_OFFSET, 16'($urandom));
        cfg_write(htfd_pkg::CFG_HUM_OFFSET, 16'($urandom));
        failure_run(12);
        random_traffic(35);
        wait_idle();

        repeat (3) begin
            cfg_write(htfd_pkg::CFG_ERROR_LIMIT, 16'($urandom_range(1, 4)));
            cfg_write(htfd_pkg::CFG_TEMP_OFFSET, 16'($urandom_range(0, 2000)) - 16'd1000);
            cfg_write(htfd_pkg::CFG_HUM_OFFSET, 16'($urandom));
            random_traffic(30);
            wait_idle();
        end

        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/htfd_pkg.sv
hw/rtl/htfd_frame.sv
hw/rtl/htfd_track.sv
hw/rtl/humidity_temp_frame_decoder_unit.sv
tb/tb_top.sv
